>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define APMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apms same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define APMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apms next-cycle check failed");

`endif

>>> hdl/apms_pkg.sv
`default_nettype none

package apms_pkg;

  // Field widths
  localparam int SCORE_BITS  = 16;
  localparam int LENGTH_BITS = 16;
  localparam int MAPQ_W      = 6;

  // Derived widths
  localparam int SUM_W  = SCORE_BITS + 1;               // two mate scores
  localparam int QUO_W  = LENGTH_BITS;                  // floor(3*(len+1)/5)
  localparam int D_W    = LENGTH_BITS + 1;              // summed range
  localparam int FX_W   = 27;                           // fraction bits
  localparam int PROD_W = D_W + FX_W;                   // range * fraction
  localparam int WIDE_W = ((SUM_W > D_W) ? SUM_W : D_W) + 2;
  localparam int CMP_W  = WIDE_W + FX_W;

  // Divide by five through a reciprocal: exact for x < 2^(SHIFT-2)
  localparam int X_W     = LENGTH_BITS + 2;
  localparam int SHIFT   = LENGTH_BITS + 4;
  localparam int RECIP_W = SHIFT - 1;
  localparam int QPROD_W = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP5 =
    RECIP_W'(((64'd1 << SHIFT) + 64'd4) / 64'd5);

  // Threshold fractions, value K / 2^27
  localparam int FX_NUM = 13;
  localparam int FXI_01  = 0;
  localparam int FXI_02  = 1;
  localparam int FXI_03  = 2;
  localparam int FXI_04  = 3;
  localparam int FXI_05  = 4;
  localparam int FXI_06  = 5;
  localparam int FXI_07  = 6;
  localparam int FXI_08  = 7;
  localparam int FXI_09  = 8;
  localparam int FXI_084 = 9;
  localparam int FXI_068 = 10;
  localparam int FXI_088 = 11;
  localparam int FXI_067 = 12;

  localparam logic [FX_W-1:0] FX_TAB [FX_NUM] = '{
    27'd13421773,  27'd26843546,  27'd40265320,  27'd53687092,
    27'd67108864,  27'd80530640,  27'd93952408,  27'd107374184,
    27'd120795952, 27'd112742888, 27'd91268056,  27'd118111600,
    27'd89925880
  };

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_ONE  = 2'd1,
    SRC_TWO  = 2'd2
  } src_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score_src1_mate1;
    logic signed [SCORE_BITS-1:0] score_src1_mate2;
    logic signed [SCORE_BITS-1:0] score_src2_mate1;
    logic signed [SCORE_BITS-1:0] score_src2_mate2;
    logic [LENGTH_BITS-1:0]       length_mate1;
    logic [LENGTH_BITS-1:0]       length_mate2;
    logic                         is_paired;
  } in_item_t;

  typedef struct packed {
    src_t              chosen_source;
    logic [MAPQ_W-1:0] mapq;
    logic              keep;
  } out_item_t;

  // Winner / runner-up pair handed to the grading pipeline
  typedef struct packed {
    src_t                    choice;
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W-1:0] second;
    logic [D_W-1:0]          range;
  } pair_t;

  // Graded result handed back to the top level
  typedef struct packed {
    src_t              choice;
    logic [MAPQ_W-1:0] mapq;
  } grade_t;

endpackage

`default_nettype wire

>>> hdl/apms_grade.sv
`default_nettype none

module apms_grade
  import apms_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   pair_valid,
  input  wire pair_t  pair,
  output logic        grade_valid,
  output grade_t      grade
);

  // v >= range * K / 2^27, exactly; negative v never passes
  function automatic logic at_least(input logic signed [WIDE_W-1:0] v,
                                    input logic [PROD_W-1:0] p);
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    lhs = {1'b0, v[WIDE_W-2:0], {FX_W{1'b0}}};
    rhs = CMP_W'(p);
    return !v[WIDE_W-1] && (lhs >= rhs);
  endfunction

  // ---------------- stage C: distances and scaled thresholds
  logic signed [WIDE_W-1:0] best_e, second_e, range_e;
  logic signed [WIDE_W-1:0] abs_best, abs_second, low_sum;
  logic signed [WIDE_W-1:0] over_nxt, gap_nxt;
  logic [PROD_W-1:0]        prod_nxt [FX_NUM];

  logic                     c_valid_r;
  src_t                     c_choice_r;
  logic signed [WIDE_W-1:0] c_over_r, c_gap_r;
  logic                     c_top_r, c_low_r, c_nz_r;
  logic [PROD_W-1:0]        c_prod_r [FX_NUM];

  always_comb begin
    best_e     = WIDE_W'(pair.best);
    second_e   = WIDE_W'(pair.second);
    range_e    = $signed(WIDE_W'(pair.range));
    abs_best   = best_e[WIDE_W-1] ? -best_e : best_e;
    abs_second = second_e[WIDE_W-1] ? -second_e : second_e;
    over_nxt   = best_e + range_e;
    gap_nxt    = (abs_best > abs_second) ? abs_best - abs_second : abs_second - abs_best;
    low_sum    = second_e + range_e;
  end

  for (genvar i = 0; i < FX_NUM; i++) begin : g_prod
    assign prod_nxt[i] = PROD_W'(pair.range) * PROD_W'(FX_TAB[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= pair_valid;
    end
    c_choice_r <= pair.choice;
    c_over_r   <= over_nxt;
    c_gap_r    <= gap_nxt;
    c_top_r    <= (pair.best == '0);
    c_low_r    <= low_sum[WIDE_W-1];
    c_nz_r     <= (gap_nxt != '0);
    c_prod_r   <= prod_nxt;
  end

  // ---------------- stage D: threshold compares
  logic   d_valid_r;
  src_t   d_choice_r;
  logic   d_top_r, d_low_r, d_nz_r;
  logic   o08_r, o07_r, o06_r, o05_r, o04_r, o03_r;
  logic   o084_r, o068_r, o088_r, o067_r;
  logic   g09_r, g08_r, g07_r, g06_r, g05_r, g04_r, g03_r, g02_r, g01_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= c_valid_r;
    end
    d_choice_r <= c_choice_r;
    d_top_r    <= c_top_r;
    d_low_r    <= c_low_r;
    d_nz_r     <= c_nz_r;
    o08_r      <= at_least(c_over_r, c_prod_r[FXI_08]);
    o07_r      <= at_least(c_over_r, c_prod_r[FXI_07]);
    o06_r      <= at_least(c_over_r, c_prod_r[FXI_06]);
    o05_r      <= at_least(c_over_r, c_prod_r[FXI_05]);
    o04_r      <= at_least(c_over_r, c_prod_r[FXI_04]);
    o03_r      <= at_least(c_over_r, c_prod_r[FXI_03]);
    o084_r     <= at_least(c_over_r, c_prod_r[FXI_084]);
    o068_r     <= at_least(c_over_r, c_prod_r[FXI_068]);
    o088_r     <= at_least(c_over_r, c_prod_r[FXI_088]);
    o067_r     <= at_least(c_over_r, c_prod_r[FXI_067]);
    g09_r      <= at_least(c_gap_r, c_prod_r[FXI_09]);
    g08_r      <= at_least(c_gap_r, c_prod_r[FXI_08]);
    g07_r      <= at_least(c_gap_r, c_prod_r[FXI_07]);
    g06_r      <= at_least(c_gap_r, c_prod_r[FXI_06]);
    g05_r      <= at_least(c_gap_r, c_prod_r[FXI_05]);
    g04_r      <= at_least(c_gap_r, c_prod_r[FXI_04]);
    g03_r      <= at_least(c_gap_r, c_prod_r[FXI_03]);
    g02_r      <= at_least(c_gap_r, c_prod_r[FXI_02]);
    g01_r      <= at_least(c_gap_r, c_prod_r[FXI_01]);
  end

  // ---------------- stage E: MAPQ decision tree
  logic [MAPQ_W-1:0] q;

  always_comb begin
    q = 6'd0;
    if (d_choice_r == SRC_NONE) begin
      q = 6'd0;
    end else if (d_low_r) begin
      // runner-up scored below the floor
      if      (o08_r) q = 6'd42;
      else if (o07_r) q = 6'd40;
      else if (o06_r) q = 6'd24;
      else if (o05_r) q = 6'd23;
      else if (o04_r) q = 6'd8;
      else if (o03_r) q = 6'd3;
      else            q = 6'd0;
    end else if (g09_r) begin
      q = d_top_r ? 6'd39 : 6'd33;
    end else if (g08_r) begin
      q = d_top_r ? 6'd38 : 6'd27;
    end else if (g07_r) begin
      q = d_top_r ? 6'd37 : 6'd26;
    end else if (g06_r) begin
      q = d_top_r ? 6'd36 : 6'd22;
    end else if (g05_r) begin
      if      (d_top_r) q = 6'd35;
      else if (o084_r)  q = 6'd25;
      else if (o068_r)  q = 6'd16;
      else              q = 6'd5;
    end else if (g04_r) begin
      if      (d_top_r) q = 6'd34;
      else if (o084_r)  q = 6'd21;
      else if (o068_r)  q = 6'd14;
      else              q = 6'd4;
    end else if (g03_r) begin
      if      (d_top_r) q = 6'd32;
      else if (o088_r)  q = 6'd18;
      else if (o067_r)  q = 6'd15;
      else              q = 6'd3;
    end else if (g02_r) begin
      if      (d_top_r) q = 6'd31;
      else if (o088_r)  q = 6'd17;
      else if (o067_r)  q = 6'd11;
      else              q = 6'd0;
    end else if (g01_r) begin
      if      (d_top_r) q = 6'd30;
      else if (o088_r)  q = 6'd12;
      else if (o067_r)  q = 6'd7;
      else              q = 6'd0;
    end else if (d_nz_r) begin
      q = o067_r ? 6'd6 : 6'd2;
    end else begin
      q = o067_r ? 6'd1 : 6'd0;
    end
  end

  assign grade_valid  = d_valid_r;
  assign grade.choice = d_choice_r;
  assign grade.mapq   = q;

endmodule

`default_nettype wire

>>> hdl/alignment_pair_mapq_select.sv
`default_nettype none
`include "assert_macros.svh"

// The result strobe follows the edge that accepts the item through the input,
// divide, select, scale, compare and result registers.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset: synchronous, active low; clears the pipeline valid bits and sets
// min_mapq to 0.

module alignment_pair_mapq_select_core
  import apms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item input
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  // result output
  output logic             out_valid,
  output out_item_t        out_item,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [MAPQ_W-1:0] cfg_min_mapq
);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // ---------------- configuration register
  logic [MAPQ_W-1:0] min_mapq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mapq_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_mapq_r <= cfg_min_mapq;
    end
  end

  // ---------------- input register
  logic     in_valid_r;
  in_item_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
    in_r <= in_item;
  end

  // ---------------- stage A: score sums and per-mate floors
  logic signed [SCORE_BITS-1:0] m2_src1, m2_src2;
  logic [LENGTH_BITS-1:0]       len2;
  logic [LENGTH_BITS:0]         lp1_1, lp1_2;
  logic [X_W-1:0]               x1, x2;
  logic [QPROD_W-1:0]           qp1, qp2;
  logic signed [SUM_W-1:0]      s1_nxt, s2_nxt;

  always_comb begin
    m2_src1 = in_r.is_paired ? in_r.score_src1_mate2 : '0;
    m2_src2 = in_r.is_paired ? in_r.score_src2_mate2 : '0;
    len2    = in_r.length_mate2;
    s1_nxt  = SUM_W'(in_r.score_src1_mate1) + SUM_W'(m2_src1);
    s2_nxt  = SUM_W'(in_r.score_src2_mate1) + SUM_W'(m2_src2);
    // 3*(len+1), then divide by five
    lp1_1   = {1'b0, in_r.length_mate1} + 1'b1;
    lp1_2   = {1'b0, len2} + 1'b1;
    x1      = {lp1_1, 1'b0} + {1'b0, lp1_1};
    x2      = {lp1_2, 1'b0} + {1'b0, lp1_2};
    qp1     = QPROD_W'(x1) * QPROD_W'(RECIP5);
    qp2     = QPROD_W'(x2) * QPROD_W'(RECIP5);
  end

  logic                    a_valid_r;
  logic signed [SUM_W-1:0] a_s1_r, a_s2_r;
  logic [QUO_W-1:0]        a_q1_r, a_q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid_r;
    end
    a_s1_r <= s1_nxt;
    a_s2_r <= s2_nxt;
    a_q1_r <= qp1[SHIFT +: QUO_W];
    a_q2_r <= in_r.is_paired ? qp2[SHIFT +: QUO_W] : '0;
  end

  // ---------------- stage B: winner selection and range
  pair_t pair_nxt;

  always_comb begin
    pair_nxt.range = D_W'(a_q1_r) + D_W'(a_q2_r);
    if (a_s1_r > a_s2_r) begin
      pair_nxt.choice = SRC_ONE;
      pair_nxt.best   = a_s1_r;
      pair_nxt.second = a_s2_r;
    end else if (a_s2_r > a_s1_r) begin
      pair_nxt.choice = SRC_TWO;
      pair_nxt.best   = a_s2_r;
      pair_nxt.second = a_s1_r;
    end else begin
      pair_nxt.choice = SRC_NONE;
      pair_nxt.best   = a_s1_r;
      pair_nxt.second = a_s2_r;
    end
  end

  logic  b_valid_r;
  pair_t b_pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_pair_r <= pair_nxt;
  end

  // ---------------- grading pipeline
  logic   grade_valid;
  grade_t grade;

  apms_grade u_grade (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (b_valid_r),
    .pair        (b_pair_r),
    .grade_valid (grade_valid),
    .grade       (grade)
  );

  // ---------------- result register
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  always_comb begin
    out_nxt.chosen_source = grade.choice;
    out_nxt.mapq          = grade.mapq;
    out_nxt.keep          = (grade.choice != SRC_NONE) && (grade.mapq >= min_mapq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= grade_valid;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ---------------- checks
  `APMS_ASSERT_NEXT(a_accept_enters, clk, rst_n, start && !busy, in_valid_r)
  `APMS_ASSERT_NOW(a_tie_zero, clk, rst_n, out_valid && (out_item.chosen_source == SRC_NONE),
                   (out_item.mapq == '0) && !out_item.keep)
  `APMS_ASSERT_NOW(a_mapq_range, clk, rst_n, out_valid, out_item.mapq <= 6'd42)
  `APMS_ASSERT_NOW(a_keep_has_winner, clk, rst_n, out_valid && out_item.keep,
                   (out_item.chosen_source == SRC_ONE) || (out_item.chosen_source == SRC_TWO))

endmodule

`default_nettype wire
